[sv/swpc_pkg.sv]
// swpc_pkg: shared constants for the sliding-window peak/centroid block.
// No dependencies; imported by swpc_front, swpc_divider and the top module.
package swpc_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int PEAK_SUM_W   = 16;
    localparam int PEAK_TIME_W  = 15;
    localparam int PIXEL_NUM_W  = 11;
    localparam int FRAC_BITS    = 8;
    localparam int EFF_W        = 16;

    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 12;
    localparam int WS_CFG_W     = 5;
    localparam int NS_CFG_W     = 8;
    localparam int PC_CFG_W     = 12;

    localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_SIZE       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLES_PER_PIXEL = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_COUNT       = 2'd2;

    localparam logic [WS_CFG_W-1:0] WINDOW_SIZE_RST       = 5'd6;
    localparam logic [NS_CFG_W-1:0] SAMPLES_PER_PIXEL_RST = 8'd40;
    localparam logic [PC_CFG_W-1:0] PIXEL_COUNT_RST       = 12'd1141;

    localparam int DEF_MAX_WINDOW  = 16;
    localparam int DEF_MAX_SAMPLES = 128;
    localparam int DEF_MAX_PIXELS  = 2048;

    localparam int QUEUE_DEPTH = 2;

endpackage

[sv/swpc_queue.sv]
// swpc_queue: small register FIFO between the accumulator and the divider.
// Depends on nothing beyond its parameters.
module swpc_queue #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    output logic              push_ready,
    input  logic [DATA_W-1:0] push_data,
    output logic              pop_valid,
    input  logic              pop_ready,
    output logic [DATA_W-1:0] pop_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[sv/swpc_front.sv]
// swpc_front: configuration registers, window delay line, running and weighted
// sums, peak tracking and pixel counting. Uses swpc_pkg.
module swpc_front #(
    parameter int MAX_WINDOW  = swpc_pkg::DEF_MAX_WINDOW,
    parameter int MAX_SAMPLES = swpc_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_PIXELS  = swpc_pkg::DEF_MAX_PIXELS,
    parameter int SUM_W       = swpc_pkg::SAMPLE_W + $clog2(MAX_WINDOW),
    parameter int WSUM_W      = SUM_W + $clog2(MAX_SAMPLES)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [swpc_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [swpc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [swpc_pkg::SAMPLE_W-1:0]       s_sample,
    output logic                                q_valid,
    input  logic                                q_ready,
    output logic [swpc_pkg::PEAK_SUM_W-1:0]     q_sum,
    output logic [WSUM_W-1:0]                   q_weighted,
    output logic [SUM_W-1:0]                    q_divisor,
    output logic [swpc_pkg::PIXEL_NUM_W-1:0]    q_pixel,
    output logic                                q_frame_end
);
    import swpc_pkg::*;

    localparam int CNT_W  = $clog2(MAX_SAMPLES);
    localparam int TAP_W  = $clog2(MAX_WINDOW);
    localparam int PCNT_W = ($clog2(MAX_PIXELS) < 1) ? 1 : $clog2(MAX_PIXELS);
    localparam int PROD_W = SAMPLE_W + CNT_W;

    logic [WS_CFG_W-1:0] ws_cfg_reg;
    logic [NS_CFG_W-1:0] ns_cfg_reg;
    logic [PC_CFG_W-1:0] pc_cfg_reg;

    logic [SAMPLE_W-1:0]   dl_reg [MAX_WINDOW];
    logic [SUM_W-1:0]      rs_reg, rs_next;
    logic [WSUM_W-1:0]     wsum_reg, wsum_next;
    logic [PEAK_SUM_W-1:0] best_sum_reg;
    logic [WSUM_W-1:0]     best_w_reg;
    logic [SUM_W-1:0]      best_div_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [PCNT_W-1:0]     pix_reg;

    logic [EFF_W-1:0]  ws_eff, ns_eff, pc_eff, cnt_ext;
    logic              emit, frame_end, accept, clear, cfg_clear, take;
    logic [TAP_W-1:0]  tap_idx;
    logic [SAMPLE_W-1:0] old;
    logic [CNT_W-1:0]  age;
    logic [PROD_W-1:0] prod_new, prod_old;

    always_comb begin
        if (ws_cfg_reg == '0) begin
            ws_eff = EFF_W'(1);
        end else if (EFF_W'(ws_cfg_reg) > EFF_W'(MAX_WINDOW)) begin
            ws_eff = EFF_W'(MAX_WINDOW);
        end else begin
            ws_eff = EFF_W'(ws_cfg_reg);
        end
        if (ns_cfg_reg < NS_CFG_W'(2)) begin
            ns_eff = EFF_W'(2);
        end else if (EFF_W'(ns_cfg_reg) > EFF_W'(MAX_SAMPLES)) begin
            ns_eff = EFF_W'(MAX_SAMPLES);
        end else begin
            ns_eff = EFF_W'(ns_cfg_reg);
        end
        if (pc_cfg_reg == '0) begin
            pc_eff = EFF_W'(1);
        end else if (EFF_W'(pc_cfg_reg) > EFF_W'(MAX_PIXELS)) begin
            pc_eff = EFF_W'(MAX_PIXELS);
        end else begin
            pc_eff = EFF_W'(pc_cfg_reg);
        end
    end

    assign cnt_ext   = EFF_W'(cnt_reg);
    assign emit      = (cnt_ext >= ns_eff - 1'b1);
    assign frame_end = (EFF_W'(pix_reg) >= pc_eff - 1'b1);

    assign s_ready = !emit || q_ready;
    assign accept  = s_valid && s_ready;
    assign q_valid = s_valid && emit;

    assign q_sum       = best_sum_reg;
    assign q_weighted  = best_w_reg;
    assign q_divisor   = best_div_reg;
    assign q_pixel     = PIXEL_NUM_W'(pix_reg);
    assign q_frame_end = frame_end;

    // oldest sample leaving the window
    assign tap_idx = TAP_W'(ws_eff - 1'b1);
    assign old     = dl_reg[tap_idx];
    assign age     = CNT_W'(cnt_ext - ws_eff);

    always_comb begin
        prod_new = PROD_W'(s_sample) * PROD_W'(cnt_reg);
        prod_old = (cnt_ext >= ws_eff) ? PROD_W'(old) * PROD_W'(age) : '0;
        rs_next   = rs_reg + SUM_W'(s_sample) - SUM_W'(old);
        wsum_next = wsum_reg + WSUM_W'(prod_new) - WSUM_W'(prod_old);
        take = (cnt_ext + 1'b1 >= ws_eff)
            && ((cnt_ext + 1'b1 == ws_eff) || (rs_next > SUM_W'(best_sum_reg)));
    end

    assign cfg_clear = cfg_wr_en
        && ((cfg_wr_index == REG_WINDOW_SIZE) || (cfg_wr_index == REG_SAMPLES_PER_PIXEL));
    assign clear = cfg_clear || (accept && emit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ws_cfg_reg   <= WINDOW_SIZE_RST;
            ns_cfg_reg   <= SAMPLES_PER_PIXEL_RST;
            pc_cfg_reg   <= PIXEL_COUNT_RST;
            pix_reg      <= '0;
            cnt_reg      <= '0;
            rs_reg       <= '0;
            wsum_reg     <= '0;
            best_sum_reg <= '0;
            best_w_reg   <= '0;
            best_div_reg <= '0;
            for (int k = 0; k < MAX_WINDOW; k++) begin
                dl_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_WINDOW_SIZE: begin
                        ws_cfg_reg <= cfg_wr_data[WS_CFG_W-1:0];
                    end
                    REG_SAMPLES_PER_PIXEL: begin
                        ns_cfg_reg <= cfg_wr_data[NS_CFG_W-1:0];
                    end
                    REG_PIXEL_COUNT: begin
                        pc_cfg_reg <= cfg_wr_data[PC_CFG_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (accept && emit) begin
                pix_reg <= frame_end ? '0 : pix_reg + 1'b1;
            end
            if (clear) begin
                cnt_reg      <= '0;
                rs_reg       <= '0;
                wsum_reg     <= '0;
                best_sum_reg <= '0;
                best_w_reg   <= '0;
                best_div_reg <= '0;
                for (int k = 0; k < MAX_WINDOW; k++) begin
                    dl_reg[k] <= '0;
                end
            end else if (accept) begin
                cnt_reg  <= cnt_reg + 1'b1;
                rs_reg   <= rs_next;
                wsum_reg <= wsum_next;
                dl_reg[0] <= s_sample;
                for (int k = 1; k < MAX_WINDOW; k++) begin
                    dl_reg[k] <= dl_reg[k-1];
                end
                if (take) begin
                    best_sum_reg <= PEAK_SUM_W'(rs_next);
                    best_w_reg   <= wsum_next;
                    best_div_reg <= rs_next;
                end
            end
        end
    end

endmodule

[sv/swpc_divider.sv]
// swpc_divider: per-pixel centroid, weighted sum * 256 / sum, one quotient bit a
// cycle, saturating; drives the registered result channel. Uses swpc_pkg.
module swpc_divider #(
    parameter int SUM_W  = 20,
    parameter int WSUM_W = 27
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                e_valid,
    output logic                                e_ready,
    input  logic [swpc_pkg::PEAK_SUM_W-1:0]     e_sum,
    input  logic [WSUM_W-1:0]                   e_weighted,
    input  logic [SUM_W-1:0]                    e_divisor,
    input  logic [swpc_pkg::PIXEL_NUM_W-1:0]    e_pixel,
    input  logic                                e_frame_end,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swpc_pkg::PEAK_SUM_W-1:0]     m_peak_sum,
    output logic [swpc_pkg::PEAK_TIME_W-1:0]    m_peak_time,
    output logic [swpc_pkg::PIXEL_NUM_W-1:0]    m_pixel_number,
    output logic                                m_frame_end
);
    import swpc_pkg::*;

    localparam int DVD_W  = WSUM_W + FRAC_BITS;
    localparam int TOP_W  = DVD_W - PEAK_TIME_W;
    localparam int CMP_W  = (TOP_W > SUM_W) ? TOP_W : SUM_W;
    localparam int STEP_W = $clog2(PEAK_TIME_W + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]             state_reg, state_next;
    logic [SUM_W-1:0]       rem_reg, rem_next;
    logic [PEAK_TIME_W-1:0] low_reg, low_next;
    logic [PEAK_TIME_W-1:0] q_reg, q_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [SUM_W-1:0]       div_reg;
    logic [PEAK_SUM_W-1:0]  sum_reg;
    logic [PIXEL_NUM_W-1:0] pix_reg;
    logic                   fe_reg;

    logic                   m_valid_reg, m_valid_next;
    logic [PEAK_SUM_W-1:0]  m_sum_reg;
    logic [PEAK_TIME_W-1:0] m_time_reg;
    logic [PIXEL_NUM_W-1:0] m_pix_reg;
    logic                   m_fe_reg;

    logic [DVD_W-1:0] dvd;
    logic [TOP_W-1:0] dvd_top;
    logic             sat, load, out_load;
    logic [SUM_W:0]   trial, trial_sub;

    assign e_ready  = (state_reg == ST_IDLE);
    assign load     = e_valid && e_ready;
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    assign dvd     = {e_weighted, {FRAC_BITS{1'b0}}};
    assign dvd_top = dvd[DVD_W-1:PEAK_TIME_W];
    // quotient needs more than 15 bits
    assign sat     = (CMP_W'(dvd_top) >= CMP_W'(e_divisor));

    assign trial     = {rem_reg, low_reg[PEAK_TIME_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};

    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        q_next     = q_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (load) begin
                    rem_next  = SUM_W'(dvd_top);
                    low_next  = dvd[PEAK_TIME_W-1:0];
                    step_next = '0;
                    if (e_divisor == '0) begin
                        q_next     = '0;
                        state_next = ST_DONE;
                    end else if (sat) begin
                        q_next     = '1;
                        state_next = ST_DONE;
                    end else begin
                        q_next     = '0;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (trial >= {1'b0, div_reg}) begin
                    rem_next = SUM_W'(trial_sub);
                    q_next   = {q_reg[PEAK_TIME_W-2:0], 1'b1};
                end else begin
                    rem_next = SUM_W'(trial);
                    q_next   = {q_reg[PEAK_TIME_W-2:0], 1'b0};
                end
                low_next  = {low_reg[PEAK_TIME_W-2:0], 1'b0};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(PEAK_TIME_W - 1)) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        q_reg    <= q_next;
        step_reg <= step_next;
        if (load) begin
            div_reg <= e_divisor;
            sum_reg <= e_sum;
            pix_reg <= e_pixel;
            fe_reg  <= e_frame_end;
        end
        if (out_load) begin
            m_sum_reg  <= sum_reg;
            m_time_reg <= q_reg;
            m_pix_reg  <= pix_reg;
            m_fe_reg   <= fe_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_peak_sum     = m_sum_reg;
    assign m_peak_time    = m_time_reg;
    assign m_pixel_number = m_pix_reg;
    assign m_frame_end    = m_fe_reg;

endmodule

[sv/sliding_window_peak_centroid_top.sv]
// Throughput: one sample per cycle, stalled on a pixel's last sample while the queue
// is full; the divider takes one pixel at a time and is busy from load until its
// result is registered, so short pixels are paced by it through a two-entry queue.
// Each result passes the queue, the divider load, the division steps (skipped for a
// zero sum or saturation), done state and output register. Reset: synchronous,
// active low, registers to their defaults, all sums, counters and queue cleared.
module sliding_window_peak_centroid_top #(
    parameter int MAX_WINDOW  = swpc_pkg::DEF_MAX_WINDOW,
    parameter int MAX_SAMPLES = swpc_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_PIXELS  = swpc_pkg::DEF_MAX_PIXELS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [swpc_pkg::CFG_INDEX_W-1:0]    cfg_wr_index,
    input  logic [swpc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [swpc_pkg::SAMPLE_W-1:0]       s_sample,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [swpc_pkg::PEAK_SUM_W-1:0]     m_peak_sum,
    output logic [swpc_pkg::PEAK_TIME_W-1:0]    m_peak_time,
    output logic [swpc_pkg::PIXEL_NUM_W-1:0]    m_pixel_number,
    output logic                                m_frame_end
);
    import swpc_pkg::*;

    localparam int SUM_W   = SAMPLE_W + $clog2(MAX_WINDOW);
    localparam int WSUM_W  = SUM_W + $clog2(MAX_SAMPLES);
    localparam int ENTRY_W = PEAK_SUM_W + WSUM_W + SUM_W + PIXEL_NUM_W + 1;

    logic                   q_valid, q_ready;
    logic [PEAK_SUM_W-1:0]  q_sum;
    logic [WSUM_W-1:0]      q_weighted;
    logic [SUM_W-1:0]       q_divisor;
    logic [PIXEL_NUM_W-1:0] q_pixel;
    logic                   q_frame_end;

    logic                   e_valid, e_ready;
    logic [ENTRY_W-1:0]     push_entry, pop_entry;
    logic [PEAK_SUM_W-1:0]  e_sum;
    logic [WSUM_W-1:0]      e_weighted;
    logic [SUM_W-1:0]       e_divisor;
    logic [PIXEL_NUM_W-1:0] e_pixel;
    logic                   e_frame_end;

    swpc_front #(
        .MAX_WINDOW  (MAX_WINDOW),
        .MAX_SAMPLES (MAX_SAMPLES),
        .MAX_PIXELS  (MAX_PIXELS),
        .SUM_W       (SUM_W),
        .WSUM_W      (WSUM_W)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_sample     (s_sample),
        .q_valid      (q_valid),
        .q_ready      (q_ready),
        .q_sum        (q_sum),
        .q_weighted   (q_weighted),
        .q_divisor    (q_divisor),
        .q_pixel      (q_pixel),
        .q_frame_end  (q_frame_end)
    );

    assign push_entry = {q_sum, q_weighted, q_divisor, q_pixel, q_frame_end};

    swpc_queue #(
        .DATA_W (ENTRY_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (q_valid),
        .push_ready (q_ready),
        .push_data  (push_entry),
        .pop_valid  (e_valid),
        .pop_ready  (e_ready),
        .pop_data   (pop_entry)
    );

    assign {e_sum, e_weighted, e_divisor, e_pixel, e_frame_end} = pop_entry;

    swpc_divider #(
        .SUM_W  (SUM_W),
        .WSUM_W (WSUM_W)
    ) u_divider (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .e_valid        (e_valid),
        .e_ready        (e_ready),
        .e_sum          (e_sum),
        .e_weighted     (e_weighted),
        .e_divisor      (e_divisor),
        .e_pixel        (e_pixel),
        .e_frame_end    (e_frame_end),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_peak_sum     (m_peak_sum),
        .m_peak_time    (m_peak_time),
        .m_pixel_number (m_pixel_number),
        .m_frame_end    (m_frame_end)
    );

endmodule
